@@ sv/vbw_pkg.sv @@
// ============================================================================
// vbw_pkg - shared types and constants for the video bitstream writer
// Opcodes, decoded command format, result beat layout and state encodings.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package vbw_pkg;

  // Input opcodes
  typedef enum logic [3:0] {
    OP_BITS_EP    = 4'd0,
    OP_RAW_BITS   = 4'd1,
    OP_UE         = 4'd2,
    OP_SE         = 4'd3,
    OP_ALIGN_ZERO = 4'd4,
    OP_ALIGN_ONE  = 4'd5,
    OP_TRAILING   = 4'd6,
    OP_FLUSH      = 4'd7,
    OP_RESTART    = 4'd8
  } opcode_e;

  // Decoded command kinds handed from front to back
  typedef enum logic [2:0] {
    CMD_PUSH,
    CMD_ALIGN0,
    CMD_ALIGN1,
    CMD_TRAIL,
    CMD_FLUSH,
    CMD_RESTART,
    CMD_NOP
  } cmd_kind_e;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SHIFT,
    BK_PEND,
    BK_FLUSH,
    BK_STATUS
  } back_state_e;

  localparam int unsigned SHREG_W    = 64;  // MSB-aligned bit staging register
  localparam int unsigned NBITS_W    = 6;   // up to 63 bits per command
  localparam int unsigned CMDQ_DEPTH = 2;
  localparam int unsigned CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int unsigned CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  localparam logic [23:0] CAP_RESET  = 24'hFF_FFFF;
  localparam logic [7:0]  EP_BYTE    = 8'h03;

  typedef struct packed {
    cmd_kind_e            kind;
    logic                 ep;
    logic [NBITS_W-1:0]   nbits;
    logic [SHREG_W-1:0]   bits;   // MSB-aligned: bit 63 goes out first
  } vbw_cmd_t;

  typedef struct packed {
    logic        byte_valid;
    logic [7:0]  out_byte;
    logic        is_flush_byte;
    logic        last;
    logic        overflow;
    logic [26:0] total_bits;
    logic [23:0] emulation_count;
  } vbw_res_t;

endpackage

`default_nettype wire

@@ sv/vbw_item_if.sv @@
// ============================================================================
// vbw_item_if - input item channel
// Valid/ready channel carrying one syntax element per beat.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface vbw_item_if;
  logic        valid;
  logic        ready;
  logic [3:0]  opcode;
  logic [31:0] value;
  logic [4:0]  length;

  modport source (output valid, output opcode, output value, output length, input ready);
  modport sink   (input valid, input opcode, input value, input length, output ready);
endinterface

`default_nettype wire

@@ sv/vbw_res_if.sv @@
// ============================================================================
// vbw_res_if - result channel
// Valid/ready channel carrying one stream byte or one status beat.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface vbw_res_if;
  logic        valid;
  logic        ready;
  logic        byte_valid;
  logic [7:0]  out_byte;
  logic        is_flush_byte;
  logic        last;
  logic        overflow;
  logic [26:0] total_bits;
  logic [23:0] emulation_count;

  modport source (output valid, output byte_valid, output out_byte, output is_flush_byte,
                  output last, output overflow, output total_bits,
                  output emulation_count, input ready);
  modport sink   (input valid, input byte_valid, input out_byte, input is_flush_byte,
                  input last, input overflow, input total_bits,
                  input emulation_count, output ready);
endinterface

`default_nettype wire

@@ sv/video_bitstream_writer_top.sv @@
// Result path: decode register, command queue, byte sequencer, output register.
// The sequencer finishes one item before it takes the next; it shifts a field in bit
//   chunks up to a byte boundary, and each inserted 0x03 and each result stall adds a
//   sequencer step.
// Reset: rst_ni is asynchronous, active low; all counts clear, the capacity
//   register returns to 0xFFFFFF. No clearing pass is needed.
// ============================================================================
// video_bitstream_writer_top - video bitstream bit writer
// Packs fields MSB-first into bytes with emulation prevention, Exp-Golomb
// coding, alignment and a byte capacity limit.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module video_bitstream_writer_top #(
  // length values above this are clamped
  parameter int unsigned MAX_FIELD_BITS = 24
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,     // capacity_bytes write strobe
  input  wire logic [23:0] cfg_wdata_i,  // capacity_bytes value
  vbw_item_if.sink         item_i,
  vbw_res_if.source        res_o
);

  // Front end: one decode register. UE/SE code values (v+1, zigzag for SE)
  // are formed on acceptance; the bit length and MSB alignment are derived
  // on the way into the queue.
  logic               f_valid, f_ready;
  vbw_pkg::vbw_cmd_t  f_cmd;

  // Queue output to the sequencer
  logic               q_valid, q_ready;
  vbw_pkg::vbw_cmd_t  q_cmd;

  vbw_front #(
    .MAX_FIELD_BITS (MAX_FIELD_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i),
    .cmd_valid_o (f_valid),
    .cmd_ready_i (f_ready),
    .cmd_o       (f_cmd)
  );

  // Two-entry queue lets decode run ahead while the sequencer is busy
  // emitting a long code or stalled by the result sink.
  vbw_cmd_fifo u_cmdq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_cmd),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_cmd)
  );

  // Back end: shifts up to one byte's worth of bits per cycle into the
  // partial byte, emits completed bytes through a single output register,
  // applies 0x03 insertion, capacity check and sticky overflow, then sends
  // one status beat (last) per item.
  vbw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_ready),
    .cmd_i       (q_cmd),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire

@@ sv/vbw_front.sv @@
// ============================================================================
// vbw_front - item decode
// Accepts items, forms the code value, then builds an MSB-aligned command.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module vbw_front #(
  parameter int unsigned MAX_FIELD_BITS = 24
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  vbw_item_if.sink              item_i,
  output logic                  cmd_valid_o,
  input  wire logic             cmd_ready_i,
  output vbw_pkg::vbw_cmd_t     cmd_o
);

  // decode register
  logic                     a_valid_q;
  vbw_pkg::cmd_kind_e       a_kind_q,  a_kind_d;
  logic                     a_ep_q,    a_ep_d;
  logic                     a_eg_q,    a_eg_d;   // Exp-Golomb: length from code value
  logic [31:0]              a_data_q,  a_data_d;
  logic [5:0]               a_n_q,     a_n_d;

  logic [5:0]  len_c;
  logic [31:0] masked;
  logic [31:0] neg;
  logic        take;

  // index of the highest set bit, five halving steps
  function automatic logic [4:0] msb_pos(input logic [31:0] x);
    logic [31:0] w;
    logic [4:0]  p;
    w = x;
    p = '0;
    if (w[31:16] != '0) begin p[4] = 1'b1; w = w >> 16; end
    if (w[15:8]  != '0) begin p[3] = 1'b1; w = w >> 8;  end
    if (w[7:4]   != '0) begin p[2] = 1'b1; w = w >> 4;  end
    if (w[3:2]   != '0) begin p[1] = 1'b1; w = w >> 2;  end
    if (w[1])           begin p[0] = 1'b1;              end
    return p;
  endfunction

  assign take         = item_i.valid && item_i.ready;
  assign item_i.ready = !a_valid_q || cmd_ready_i;

  assign len_c  = ({1'b0, item_i.length} > 6'(MAX_FIELD_BITS)) ? 6'(MAX_FIELD_BITS)
                                                                 : {1'b0, item_i.length};
  assign masked = item_i.value & ~(32'hFFFF_FFFF << len_c);
  assign neg    = ~item_i.value + 32'd1;

  always_comb begin
    a_kind_d = vbw_pkg::CMD_NOP;
    a_ep_d   = 1'b0;
    a_eg_d   = 1'b0;
    a_data_d = masked;
    a_n_d    = len_c;
    case (item_i.opcode)
      vbw_pkg::OP_BITS_EP: begin
        a_kind_d = vbw_pkg::CMD_PUSH;
        a_ep_d   = 1'b1;
      end
      vbw_pkg::OP_RAW_BITS: begin
        a_kind_d = vbw_pkg::CMD_PUSH;
      end
      vbw_pkg::OP_UE: begin
        a_kind_d = vbw_pkg::CMD_PUSH;
        a_ep_d   = 1'b1;
        a_eg_d   = 1'b1;
        // code value is v+1, with all-ones clamped to the largest legal v
        a_data_d = (item_i.value == 32'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                                    : item_i.value + 32'd1;
      end
      vbw_pkg::OP_SE: begin
        a_kind_d = vbw_pkg::CMD_PUSH;
        a_ep_d   = 1'b1;
        a_eg_d   = 1'b1;
        if (!item_i.value[31]) begin
          a_data_d = (item_i.value == '0) ? 32'd1 : {item_i.value[30:0], 1'b0};
        end else if (item_i.value == 32'h8000_0000) begin
          a_data_d = 32'hFFFF_FFFF;   // most negative value clamps
        end else begin
          a_data_d = {neg[30:0], 1'b1};
        end
      end
      vbw_pkg::OP_ALIGN_ZERO: a_kind_d = vbw_pkg::CMD_ALIGN0;
      vbw_pkg::OP_ALIGN_ONE:  a_kind_d = vbw_pkg::CMD_ALIGN1;
      vbw_pkg::OP_TRAILING:   a_kind_d = vbw_pkg::CMD_TRAIL;
      vbw_pkg::OP_FLUSH:      a_kind_d = vbw_pkg::CMD_FLUSH;
      vbw_pkg::OP_RESTART:    a_kind_d = vbw_pkg::CMD_RESTART;
      default:                a_kind_d = vbw_pkg::CMD_NOP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (item_i.ready) begin
      a_valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      a_kind_q <= a_kind_d;
      a_ep_q   <= a_ep_d;
      a_eg_q   <= a_eg_d;
      a_data_q <= a_data_d;
      a_n_q    <= a_n_d;
    end
  end

  // Exp-Golomb word is the code value right-aligned in 2*msb+1 bits
  logic [5:0] n_cmd;
  logic [5:0] lsh;

  assign n_cmd = a_eg_q ? {msb_pos(a_data_q), 1'b1} : a_n_q;
  assign lsh   = 6'(7'd64 - {1'b0, n_cmd});

  assign cmd_valid_o = a_valid_q;
  assign cmd_o.kind  = a_kind_q;
  assign cmd_o.ep    = a_ep_q;
  assign cmd_o.nbits = n_cmd;
  assign cmd_o.bits  = {32'd0, a_data_q} << lsh;

endmodule

`default_nettype wire

@@ sv/vbw_cmd_fifo.sv @@
// ============================================================================
// vbw_cmd_fifo - command queue
// Short first-in first-out queue between decode and the byte sequencer.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module vbw_cmd_fifo (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_valid_i,
  output logic                   push_ready_o,
  input  wire vbw_pkg::vbw_cmd_t push_data_i,
  output logic                   pop_valid_o,
  input  wire logic              pop_ready_i,
  output vbw_pkg::vbw_cmd_t      pop_data_o
);

  vbw_pkg::vbw_cmd_t                    entry_q [vbw_pkg::CMDQ_DEPTH];
  logic [vbw_pkg::CMDQ_PTR_W-1:0]       wptr_q, rptr_q;
  logic [vbw_pkg::CMDQ_CNT_W-1:0]       count_q;
  logic                                 do_push, do_pop;

  assign push_ready_o = (count_q != vbw_pkg::CMDQ_CNT_W'(vbw_pkg::CMDQ_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = entry_q[rptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) wptr_q <= wptr_q + 1'b1;
      if (do_pop)  rptr_q <= rptr_q + 1'b1;
      if (do_push && !do_pop)      count_q <= count_q + 1'b1;
      else if (do_pop && !do_push) count_q <= count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

@@ sv/vbw_back.sv @@
// ============================================================================
// vbw_back - byte sequencer
// Packs command bits into bytes, inserts 0x03, tracks counts and capacity.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module vbw_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [23:0]       cfg_wdata_i,
  input  wire logic              cmd_valid_i,
  output logic                   cmd_ready_o,
  input  wire vbw_pkg::vbw_cmd_t cmd_i,
  vbw_res_if.source              res_o
);

  vbw_pkg::back_state_e state_q, state_d;
  logic [63:0] sh_q,   sh_d;
  logic [5:0]  rem_q,  rem_d;
  logic        ep_q,   ep_d;
  logic [7:0]  pend_q, pend_d;
  logic [6:0]  part_q, part_d;
  logic [2:0]  pc_q,   pc_d;
  logic [1:0]  zr_q,   zr_d;
  logic [23:0] bw_q,   bw_d;
  logic        ovf_q,  ovf_d;
  logic [23:0] emu_q,  emu_d;
  logic [23:0] cap_q;

  logic              out_valid_q;
  vbw_pkg::vbw_res_t res_q, res_d;
  logic              load_out;

  logic        out_free;
  logic        full;
  logic [3:0]  free;
  logic [3:0]  take;
  logic [3:0]  cnt;
  logic [14:0] merged;
  logic [7:0]  cur_byte;
  logic [7:0]  flush_byte;

  function automatic logic [1:0] zr_next(input logic [1:0] zr, input logic [7:0] b);
    if (b != 8'd0) return 2'd0;
    return (zr < 2'd2) ? zr + 2'd1 : 2'd2;
  endfunction

  assign out_free   = !out_valid_q || res_o.ready;
  assign full       = (bw_q >= cap_q);
  assign free       = 4'd8 - {1'b0, pc_q};
  assign take       = (rem_q < {2'b00, free}) ? rem_q[3:0] : free;
  assign cnt        = {1'b0, pc_q} + take;
  assign merged     = ({8'd0, part_q} << take) | ({7'd0, sh_q[63:56]} >> (4'd8 - take));
  assign cur_byte   = merged[7:0];
  assign flush_byte = {1'b0, part_q} << free;

  always_comb begin
    state_d     = state_q;
    sh_d        = sh_q;
    rem_d       = rem_q;
    ep_d        = ep_q;
    pend_d      = pend_q;
    part_d      = part_q;
    pc_d        = pc_q;
    zr_d        = zr_q;
    bw_d        = bw_q;
    ovf_d       = ovf_q;
    emu_d       = emu_q;
    cmd_ready_o = 1'b0;
    load_out    = 1'b0;
    res_d       = '0;

    case (state_q)
      vbw_pkg::BK_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          state_d = vbw_pkg::BK_STATUS;
          case (cmd_i.kind)
            vbw_pkg::CMD_PUSH: begin
              if (!ovf_q) begin
                sh_d    = cmd_i.bits;
                rem_d   = cmd_i.nbits;
                ep_d    = cmd_i.ep;
                state_d = vbw_pkg::BK_SHIFT;
              end
            end
            vbw_pkg::CMD_ALIGN0, vbw_pkg::CMD_ALIGN1: begin
              if (!ovf_q && pc_q != 3'd0) begin
                sh_d    = (cmd_i.kind == vbw_pkg::CMD_ALIGN1) ? '1 : '0;
                rem_d   = {2'b00, free};
                ep_d    = 1'b0;
                state_d = vbw_pkg::BK_SHIFT;
              end
            end
            vbw_pkg::CMD_TRAIL: begin
              // stop bit then zero pad to the byte boundary, all under EP
              if (!ovf_q) begin
                sh_d    = {1'b1, 63'd0};
                rem_d   = {2'b00, free};
                ep_d    = 1'b1;
                state_d = vbw_pkg::BK_SHIFT;
              end
            end
            vbw_pkg::CMD_FLUSH: begin
              if (!ovf_q && pc_q != 3'd0) state_d = vbw_pkg::BK_FLUSH;
            end
            vbw_pkg::CMD_RESTART: begin
              part_d = '0;
              pc_d   = '0;
              zr_d   = '0;
              bw_d   = '0;
              ovf_d  = 1'b0;
              emu_d  = '0;
            end
            default: state_d = vbw_pkg::BK_STATUS;
          endcase
        end
      end

      vbw_pkg::BK_SHIFT: begin
        if (rem_q == '0) begin
          state_d = vbw_pkg::BK_STATUS;
        end else if (cnt != 4'd8) begin
          part_d = merged[6:0];
          pc_d   = cnt[2:0];
          sh_d   = sh_q << take;
          rem_d  = rem_q - {2'b00, take};
        end else if (out_free) begin
          part_d = '0;
          pc_d   = '0;
          sh_d   = sh_q << take;
          rem_d  = rem_q - {2'b00, take};
          if (ep_q && zr_q == 2'd2 && cur_byte < 8'd4) begin
            if (full) begin
              ovf_d   = 1'b1;
              state_d = vbw_pkg::BK_STATUS;
            end else begin
              bw_d             = bw_q + 24'd1;
              emu_d            = emu_q + 24'd1;
              zr_d             = '0;
              pend_d           = cur_byte;
              load_out         = 1'b1;
              res_d.byte_valid = 1'b1;
              res_d.out_byte   = vbw_pkg::EP_BYTE;
              state_d          = vbw_pkg::BK_PEND;
            end
          end else if (full) begin
            ovf_d   = 1'b1;
            state_d = vbw_pkg::BK_STATUS;
          end else begin
            bw_d             = bw_q + 24'd1;
            load_out         = 1'b1;
            res_d.byte_valid = 1'b1;
            res_d.out_byte   = cur_byte;
            if (ep_q) zr_d = zr_next(zr_q, cur_byte);
          end
        end
      end

      // data byte held back behind an inserted 0x03
      vbw_pkg::BK_PEND: begin
        if (out_free) begin
          if (full) begin
            ovf_d   = 1'b1;
            state_d = vbw_pkg::BK_STATUS;
          end else begin
            bw_d             = bw_q + 24'd1;
            zr_d             = zr_next(zr_q, pend_q);
            load_out         = 1'b1;
            res_d.byte_valid = 1'b1;
            res_d.out_byte   = pend_q;
            state_d          = vbw_pkg::BK_SHIFT;
          end
        end
      end

      vbw_pkg::BK_FLUSH: begin
        if (full) begin
          ovf_d   = 1'b1;
          state_d = vbw_pkg::BK_STATUS;
        end else if (out_free) begin
          load_out            = 1'b1;
          res_d.byte_valid    = 1'b1;
          res_d.out_byte      = flush_byte;
          res_d.is_flush_byte = 1'b1;
          state_d             = vbw_pkg::BK_STATUS;
        end
      end

      vbw_pkg::BK_STATUS: begin
        if (out_free) begin
          load_out   = 1'b1;
          res_d.last = 1'b1;
          state_d    = vbw_pkg::BK_IDLE;
        end
      end

      default: state_d = vbw_pkg::BK_IDLE;
    endcase

    // status fields reflect state after this beat's byte
    res_d.overflow        = ovf_d;
    res_d.total_bits      = {bw_d, pc_d};
    res_d.emulation_count = emu_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vbw_pkg::BK_IDLE;
      part_q      <= '0;
      pc_q        <= '0;
      zr_q        <= '0;
      bw_q        <= '0;
      ovf_q       <= 1'b0;
      emu_q       <= '0;
      cap_q       <= vbw_pkg::CAP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      part_q  <= part_d;
      pc_q    <= pc_d;
      zr_q    <= zr_d;
      bw_q    <= bw_d;
      ovf_q   <= ovf_d;
      emu_q   <= emu_d;
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      if (load_out)         out_valid_q <= 1'b1;
      else if (res_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q   <= sh_d;
    rem_q  <= rem_d;
    ep_q   <= ep_d;
    pend_q <= pend_d;
    if (load_out) res_q <= res_d;
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.byte_valid      = res_q.byte_valid;
  assign res_o.out_byte        = res_q.out_byte;
  assign res_o.is_flush_byte   = res_q.is_flush_byte;
  assign res_o.last            = res_q.last;
  assign res_o.overflow        = res_q.overflow;
  assign res_o.total_bits      = res_q.total_bits;
  assign res_o.emulation_count = res_q.emulation_count;

endmodule

`default_nettype wire

@@ sv/vbw_checker.sv @@
// ============================================================================
// vbw_checker - port-level checks for the bitstream writer
// Watches the result channel; attached to the top level by bind.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module vbw_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic        byte_valid_i,
  input wire logic [7:0]  out_byte_i,
  input wire logic        is_flush_byte_i,
  input wire logic        last_i,
  input wire logic        overflow_i,
  input wire logic [26:0] total_bits_i
);

  // stalled beat holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i)
      && $stable(last_i) && $stable(total_bits_i))
    else $error("result beat changed while stalled");

  // every beat is either a byte or the closing status
  a_byte_or_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (byte_valid_i != last_i))
    else $error("beat is neither byte nor status");

  // a completed stream byte leaves no partial bits behind
  a_byte_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && byte_valid_i && !is_flush_byte_i |-> total_bits_i[2:0] == 3'd0)
    else $error("stream byte with partial bits pending");

  // flush byte only exists with a partial byte pending
  a_flush_partial: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && is_flush_byte_i |-> total_bits_i[2:0] != 3'd0 && byte_valid_i)
    else $error("flush byte without partial bits");

  // nothing is written once overflow is flagged
  a_no_byte_on_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && byte_valid_i |-> !overflow_i)
    else $error("byte emitted with overflow set");

endmodule

bind video_bitstream_writer_top vbw_checker u_vbw_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (res_o.valid),
  .out_ready_i     (res_o.ready),
  .byte_valid_i    (res_o.byte_valid),
  .out_byte_i      (res_o.out_byte),
  .is_flush_byte_i (res_o.is_flush_byte),
  .last_i          (res_o.last),
  .overflow_i      (res_o.overflow),
  .total_bits_i    (res_o.total_bits)
);

`default_nettype wire

@@ tb/vbw_stream_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// vbw_stream_checker - scoreboard for the video bitstream writer
// Watches the item, result and capacity ports, predicts the byte and status
// beats of every accepted item and compares them against the result channel.
// ============================================================================

module vbw_stream_checker #(
  parameter int unsigned MAX_FIELD_BITS = 24
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [23:0] cfg_wdata_i,
  vbw_item_if              item_mon,
  vbw_res_if               res_mon,
  output int unsigned      fail_count_o,
  output int unsigned      pending_o
);

  localparam int unsigned MAX_BEATS   = 16;  // beats per item beyond this are lost
  localparam int unsigned REPORT_MAX  = 10;

  // Mirror of the writer state
  logic [23:0] capacity_q;
  logic [6:0]  part_bits_q;
  int unsigned part_cnt;
  logic [1:0]  zero_run_q;
  logic [23:0] bytes_out_q;
  logic        overflow_q;
  logic [23:0] ep_inserted_q;

  int unsigned       item_beats;
  int unsigned       reported;
  vbw_pkg::vbw_res_t expected_beats[$];

  function automatic void add_beat(logic valid, logic [7:0] data, logic flush,
                                   logic is_last);
    vbw_pkg::vbw_res_t b;
    if (item_beats >= MAX_BEATS) return;
    b.byte_valid      = valid;
    b.out_byte        = data;
    b.is_flush_byte   = flush;
    b.last            = is_last;
    b.overflow        = overflow_q;
    b.total_bits      = {bytes_out_q, 3'b000} + 27'(part_cnt);
    b.emulation_count = ep_inserted_q;
    expected_beats.push_back(b);
    item_beats++;
  endfunction

  // Sets the sticky flag when the buffer is full
  function automatic bit take_room();
    if (overflow_q || bytes_out_q >= capacity_q) begin
      overflow_q = 1'b1;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void shift_in(logic [63:0] bits, int unsigned n, bit ep);
    logic [7:0]  acc;
    int unsigned i;
    if (overflow_q) return;
    for (i = 0; i < n; i++) begin
      acc = {part_bits_q, bits[n-1-i]};
      part_cnt++;
      if (part_cnt < 8) begin
        part_bits_q = acc[6:0];
      end else begin
        part_bits_q = '0;
        part_cnt    = 0;
        if (ep && zero_run_q == 2'd2 && acc < 8'd4) begin
          if (!take_room()) return;
          bytes_out_q   = bytes_out_q + 24'd1;
          ep_inserted_q = ep_inserted_q + 24'd1;
          zero_run_q    = 2'd0;
          add_beat(1'b1, vbw_pkg::EP_BYTE, 1'b0, 1'b0);
        end
        if (!take_room()) return;
        bytes_out_q = bytes_out_q + 24'd1;
        add_beat(1'b1, acc, 1'b0, 1'b0);
        if (ep) begin
          if (acc != 8'd0) zero_run_q = 2'd0;
          else if (zero_run_q < 2'd2) zero_run_q = zero_run_q + 2'd1;
        end
      end
    end
  endfunction

  function automatic void code_ue(logic [63:0] v);
    logic [63:0] c;
    int unsigned len;
    if (v > 64'hFFFF_FFFE) v = 64'hFFFF_FFFE;
    c   = v + 64'd1;
    len = 0;
    while (len < 33 && (c >> len) != 64'd0) len++;
    shift_in(c, 2 * len - 1, 1'b1);
  endfunction

  function automatic void predict_item(logic [3:0] op, logic [31:0] val, logic [4:0] length);
    int unsigned n;
    logic [63:0] field;
    logic [15:0] padded;
    item_beats = 0;
    n     = (length > MAX_FIELD_BITS) ? MAX_FIELD_BITS : length;
    field = {32'd0, val} & ((64'd1 << n) - 64'd1);
    case (op)
      vbw_pkg::OP_BITS_EP:    shift_in(field, n, 1'b1);
      vbw_pkg::OP_RAW_BITS:   shift_in(field, n, 1'b0);
      vbw_pkg::OP_UE:         code_ue({32'd0, val});
      vbw_pkg::OP_SE: begin
        if (!val[31]) code_ue((val == 32'd0) ? 64'd0 : 2 * {32'd0, val} - 64'd1);
        else          code_ue(2 * ({32'd0, ~val} + 64'd1));
      end
      vbw_pkg::OP_ALIGN_ZERO: if (part_cnt != 0) shift_in(64'd0, 8 - part_cnt, 1'b0);
      vbw_pkg::OP_ALIGN_ONE:  if (part_cnt != 0) shift_in(64'hFF, 8 - part_cnt, 1'b0);
      vbw_pkg::OP_TRAILING: begin
        shift_in(64'd1, 1, 1'b1);
        if (part_cnt != 0 && !overflow_q) shift_in(64'd0, 8 - part_cnt, 1'b1);
      end
      vbw_pkg::OP_FLUSH: begin
        padded = {9'd0, part_bits_q} << (8 - part_cnt);
        if (!overflow_q && part_cnt != 0 && take_room())
          add_beat(1'b1, padded[7:0], 1'b1, 1'b0);
      end
      vbw_pkg::OP_RESTART: begin
        part_bits_q   = '0;
        part_cnt      = 0;
        zero_run_q    = '0;
        bytes_out_q   = '0;
        overflow_q    = 1'b0;
        ep_inserted_q = '0;
      end
      default: ;
    endcase
    add_beat(1'b0, 8'd0, 1'b0, 1'b1);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    vbw_pkg::vbw_res_t got;
    vbw_pkg::vbw_res_t want;
    if (!rst_ni) begin
      capacity_q    = vbw_pkg::CAP_RESET;
      part_bits_q   = '0;
      part_cnt      = 0;
      zero_run_q    = '0;
      bytes_out_q   = '0;
      overflow_q    = 1'b0;
      ep_inserted_q = '0;
      reported      = 0;
      fail_count_o  = 0;
      expected_beats.delete();
    end else begin
      if (cfg_we_i) capacity_q = cfg_wdata_i;
      if (item_mon.valid && item_mon.ready)
        predict_item(item_mon.opcode, item_mon.value, item_mon.length);
      if (res_mon.valid && res_mon.ready) begin
        got.byte_valid      = res_mon.byte_valid;
        got.out_byte        = res_mon.out_byte;
        got.is_flush_byte   = res_mon.is_flush_byte;
        got.last            = res_mon.last;
        got.overflow        = res_mon.overflow;
        got.total_bits      = res_mon.total_bits;
        got.emulation_count = res_mon.emulation_count;
        if (expected_beats.size() == 0) begin
          fail_count_o++;
          if (reported < REPORT_MAX)
            $display("%0t: unexpected result beat byte_valid=%0b out_byte=%02h last=%0b",
                     $time, got.byte_valid, got.out_byte, got.last);
          reported++;
        end else begin
          want = expected_beats.pop_front();
          if (got !== want) begin
            fail_count_o++;
            if (reported < REPORT_MAX)
              $display({"%0t: beat mismatch\n",
                        "  exp: bv=%0b byte=%02h flush=%0b last=%0b ovf=%0b bits=%0d emu=%0d\n",
                        "  act: bv=%0b byte=%02h flush=%0b last=%0b ovf=%0b bits=%0d emu=%0d"},
                       $time,
                       want.byte_valid, want.out_byte, want.is_flush_byte, want.last,
                       want.overflow, want.total_bits, want.emulation_count,
                       got.byte_valid, got.out_byte, got.is_flush_byte, got.last,
                       got.overflow, got.total_bits, got.emulation_count);
            reported++;
          end
        end
      end
    end
    pending_o = expected_beats.size();
  end

endmodule

@@ tb/video_bitstream_writer_top_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// video_bitstream_writer_top_tb - testbench for the video bitstream writer
// Drives syntax elements through the item channel in random bursts while the
// result channel stalls on its own pattern. A directed run covers the opcode
// corner cases, then random traffic runs under several buffer capacities.
// A side checker predicts every beat; this module only makes stimulus and
// gives the verdict.
// ============================================================================

module video_bitstream_writer_top_tb;

  // No beat in either direction for this many cycles means the block hung.
  // Worst legal quiet stretch is a receiver stall, a sender gap, the
  // pipeline latency or the pause before a capacity write, so this is
  // far above any correct run.
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 12;  // quiet time before config / verdict

  // Opcodes the block has no meaning for; it only reports status on them
  localparam logic [3:0] OP_UNUSED_LO = 4'd9;
  localparam logic [3:0] OP_UNUSED_HI = 4'd15;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [23:0] cfg_wdata;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned idle_cycles = 0;
  int unsigned burst_left  = 0;

  // Receiver stall pattern state
  int unsigned rx_mode      = 0;
  int unsigned rx_mode_left = 0;
  int unsigned rx_hold      = 0;

  vbw_item_if item_bus ();
  vbw_res_if  res_bus ();

  video_bitstream_writer_top u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .item_i      (item_bus),
    .res_o       (res_bus)
  );

  vbw_stream_checker u_chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .item_mon     (item_bus),
    .res_mon      (res_bus),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // 12 ns clock
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver: the stall mode changes at random intervals.
  //   mode 0 - always ready (no back-pressure at all)
  //   mode 1 - short stalls
  //   mode 2 - longer stalls
  initial begin
    res_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_mode_left == 0) begin
        rx_mode      = $urandom_range(0, 2);
        rx_mode_left = $urandom_range(32, 256);
      end else begin
        rx_mode_left--;
      end
      if (rx_hold == 0) begin
        res_bus.ready = 1'b1;
        case (rx_mode)
          0:       rx_hold = 0;
          1:       rx_hold = $urandom_range(0, 1);
          default: rx_hold = $urandom_range(0, 7);
        endcase
      end else begin
        res_bus.ready = 1'b0;
        rx_hold--;
      end
    end
  end

  // Hang detector: counts cycles with no beat on either channel
  always @(posedge clk) begin
    if (!rst_n || (item_bus.valid && item_bus.ready) || (res_bus.valid && res_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Presents one item from a falling edge and returns at the falling edge
  // after its beat. Bursts of back-to-back items are broken by random gaps;
  // a quarter of the bursts follow the previous one with no gap at all.
  task automatic send_item(input logic [3:0] op, input logic [31:0] val,
                           input logic [4:0] len);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        item_bus.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    item_bus.valid  = 1'b1;
    item_bus.opcode = op;
    item_bus.value  = val;
    item_bus.length = len;
    @(posedge clk);
    while (!item_bus.ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
  endtask

  // Mostly syntax elements with zero-heavy values so that runs of zero bytes
  // (and with them 0x03 insertion) come up often; alignment, flush, restart
  // and unused opcodes are sprinkled in.
  task automatic send_random_item();
    int unsigned pick;
    logic [3:0]  op;
    logic [31:0] val;
    logic [4:0]  len;
    pick = $urandom_range(0, 99);
    if (pick < 28)      op = vbw_pkg::OP_BITS_EP;
    else if (pick < 38) op = vbw_pkg::OP_RAW_BITS;
    else if (pick < 58) op = vbw_pkg::OP_UE;
    else if (pick < 73) op = vbw_pkg::OP_SE;
    else if (pick < 78) op = vbw_pkg::OP_ALIGN_ZERO;
    else if (pick < 83) op = vbw_pkg::OP_ALIGN_ONE;
    else if (pick < 88) op = vbw_pkg::OP_TRAILING;
    else if (pick < 94) op = vbw_pkg::OP_FLUSH;
    else if (pick < 97) op = vbw_pkg::OP_RESTART;
    else                op = 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    case ($urandom_range(0, 9))
      0, 1, 2: val = '0;
      3, 4:    val = 32'($urandom_range(0, 3));
      5, 6:    val = 32'($urandom_range(0, 40));
      7:       val = $urandom_range(0, 1) ? 32'h8000_0000 : 32'hFFFF_FFFF;
      default: val = $urandom;
    endcase
    len = 5'($urandom_range(0, 31));
    send_item(op, val, len);
  endtask

  // Capacity is only written with nothing in flight: wait for every
  // predicted beat, give the pipeline a few quiet cycles, then write.
  task automatic set_capacity(input logic [23:0] cap);
    item_bus.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = cap;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // One random phase: new capacity, a restart to drop any sticky overflow
  // left from the previous phase, then random traffic.
  task automatic run_phase(input logic [23:0] cap, input int unsigned n_items);
    set_capacity(cap);
    send_item(vbw_pkg::OP_RESTART, $urandom, 5'($urandom_range(0, 31)));
    repeat (n_items) send_random_item();
  endtask

  initial begin
    // Everything the block sees is known from time zero
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    item_bus.valid  = 1'b0;
    item_bus.opcode = '0;
    item_bus.value  = '0;
    item_bus.length = '0;

    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // ---- directed: full buffer size ----
    set_capacity(vbw_pkg::CAP_RESET);
    send_item(vbw_pkg::OP_BITS_EP, 32'hFFFF_FFFF, 5'd0);   // empty field
    send_item(vbw_pkg::OP_BITS_EP, 32'hFFFF_FFFF, 5'd24);  // widest field, upper bits ignored
    send_item(vbw_pkg::OP_RAW_BITS, 32'h00AB_CDEF, 5'd31); // length clamped to the field limit
    send_item(vbw_pkg::OP_BITS_EP, 32'h0, 5'd16);          // two zero bytes ...
    send_item(vbw_pkg::OP_BITS_EP, 32'h1, 5'd8);           // ... then 0x01: 0x03 goes in first
    send_item(vbw_pkg::OP_BITS_EP, 32'h0, 5'd16);
    send_item(vbw_pkg::OP_RAW_BITS, 32'h2, 5'd8);          // raw bytes never get 0x03
    send_item(vbw_pkg::OP_BITS_EP, 32'h0, 5'd8);           // zero run survived the raw byte
    send_item(vbw_pkg::OP_UE, 32'h0, 5'd0);
    send_item(vbw_pkg::OP_UE, 32'hFFFF_FFFF, 5'd0);        // coded as the largest legal value
    send_item(vbw_pkg::OP_UE, 32'hFFFF_FFFE, 5'd0);
    send_item(vbw_pkg::OP_SE, 32'h0, 5'd0);
    send_item(vbw_pkg::OP_SE, 32'h1, 5'd0);
    send_item(vbw_pkg::OP_SE, 32'hFFFF_FFFF, 5'd0);
    send_item(vbw_pkg::OP_SE, 32'h8000_0000, 5'd0);        // most negative se
    send_item(vbw_pkg::OP_SE, 32'h7FFF_FFFF, 5'd0);
    send_item(vbw_pkg::OP_BITS_EP, 32'h5, 5'd3);
    send_item(vbw_pkg::OP_ALIGN_ZERO, 32'h0, 5'd0);
    send_item(vbw_pkg::OP_ALIGN_ZERO, 32'h0, 5'd0);        // already aligned: nothing
    send_item(vbw_pkg::OP_RAW_BITS, 32'h1, 5'd1);
    send_item(vbw_pkg::OP_ALIGN_ONE, 32'h0, 5'd0);
    send_item(vbw_pkg::OP_BITS_EP, 32'h15, 5'd5);
    send_item(vbw_pkg::OP_FLUSH, 32'h0, 5'd0);             // padded partial byte, state kept
    send_item(vbw_pkg::OP_TRAILING, 32'h0, 5'd0);
    send_item(vbw_pkg::OP_FLUSH, 32'h0, 5'd0);             // no partial byte: status only
    send_item(OP_UNUSED_LO, 32'hFFFF_FFFF, 5'd31);
    send_item(OP_UNUSED_HI, 32'h0, 5'd0);

    // ---- directed: zero capacity, first byte overflows ----
    set_capacity(24'd0);
    send_item(vbw_pkg::OP_BITS_EP, 32'h5, 5'd3);
    send_item(vbw_pkg::OP_FLUSH, 32'h0, 5'd0);             // no room for the partial byte
    send_item(vbw_pkg::OP_BITS_EP, 32'hAB, 5'd8);          // dropped while overflow is set
    send_item(vbw_pkg::OP_RESTART, 32'h0, 5'd0);
    send_item(vbw_pkg::OP_UE, 32'd5, 5'd0);

    // ---- random phases over a range of buffer sizes ----
    run_phase(24'd0, 15);
    run_phase(24'd3, 35);
    run_phase(24'($urandom_range(4, 120)), 55);
    run_phase(24'($urandom), 60);
    run_phase(vbw_pkg::CAP_RESET, 80);

    // Drain, then allow a few cycles for anything stray to show up
    item_bus.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
